// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the transmitter modules.
// Both macros sample on clk_i and stay quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define PTX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// The expression must never be true outside reset.
`define PTX_ASSERT_NEVER(label, expr, msg) \
  `PTX_ASSERT(label, !(expr), msg)

`endif

// File: rtl/core/ptx_pkg.sv
// ----------------------------------------------------------------------------
// Powerline command transmitter package
// Item types, section codes, register indexes and bit selection helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ptx_pkg;

  // Input item and result item.
  typedef struct packed {
    logic       op;
    logic       zero_cross;
    logic [3:0] house_code;
    logic [4:0] number_code;
  } in_item_t;

  typedef struct packed {
    logic tx_level;
    logic busy_res;
    logic done_res;
  } out_item_t;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // Configuration port.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_TICKS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_CODE  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHT_CODE = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DIM_CODE    = 2'd3;

  typedef struct packed {
    logic [15:0] pulse_ticks;
    logic [3:0]  start_code;
    logic [4:0]  bright_code;
    logic [4:0]  dim_code;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    pulse_ticks: 16'd1000,
    start_code:  4'd14,
    bright_code: 5'd11,
    dim_code:    5'd9
  };

  // Queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic       is_request;
    logic       zero_cross;
    logic [3:0] house_code;
    logic [4:0] number_code;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_head_t;

  // Sequencer constants.
  localparam logic [1:0] BURSTS_PER_BIT = 2'd3;
  localparam logic [2:0] TAIL_CROSSINGS = 3'd6;

  typedef enum logic [4:0] {
    SEC_IDLE   = 5'b00001,
    SEC_START  = 5'b00010,
    SEC_HOUSE  = 5'b00100,
    SEC_NUMBER = 5'b01000,
    SEC_TAIL   = 5'b10000
  } section_e;

  function automatic logic [2:0] sec_len(section_e sec);
    logic [2:0] len;
    unique case (sec)
      SEC_START:  len = 3'd3;
      SEC_HOUSE:  len = 3'd4;
      SEC_NUMBER: len = 3'd5;
      default:    len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic section_e sec_next(section_e sec);
    section_e nxt;
    unique case (sec)
      SEC_START:  nxt = SEC_HOUSE;
      SEC_HOUSE:  nxt = SEC_NUMBER;
      SEC_NUMBER: nxt = SEC_TAIL;
      default:    nxt = SEC_IDLE;
    endcase
    return nxt;
  endfunction

  // Level of the bit now being sent; bits go out MSB first.
  function automatic logic cur_bit(section_e sec, logic [2:0] bit_idx, logic comp,
                                   logic [3:0] start_code, logic [3:0] house,
                                   logic [4:0] number);
    logic [2:0] pos;
    logic       b;
    pos = 3'd0;
    b   = 1'b0;
    if (bit_idx < sec_len(sec)) begin
      unique case (sec)
        SEC_START: begin
          pos = 3'd2 - bit_idx;
          b   = start_code[pos[1:0]];
        end
        SEC_HOUSE: begin
          pos = 3'd3 - bit_idx;
          b   = house[pos[1:0]];
        end
        SEC_NUMBER: begin
          pos = 3'd4 - bit_idx;
          b   = number[pos];
        end
        default: b = 1'b0;
      endcase
    end
    return b ^ comp;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ptx_front.sv
// ----------------------------------------------------------------------------
// Transmitter front
// Takes input items, tags command requests and queues them for the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ptx_front #(
  parameter int unsigned QueueDepth = ptx_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ptx_pkg::in_item_t in_data_i,
  output ptx_pkg::q_head_t       head_o,
  input  wire logic              pop_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  ptx_pkg::entry_t entries_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  logic            pop;
  ptx_pkg::entry_t new_entry;

  assign in_stall_o = (cnt_q == FullCnt);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (cnt_q != '0);

  always_comb begin
    new_entry.is_request  = (in_data_i.op == ptx_pkg::OP_REQUEST);
    new_entry.zero_cross  = in_data_i.zero_cross;
    new_entry.house_code  = in_data_i.house_code;
    new_entry.number_code = in_data_i.number_code;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= new_entry;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = entries_q[rd_ptr_q];

  `PTX_ASSERT(a_cnt_in_range, cnt_q <= FullCnt, "queue count beyond depth")
  `PTX_ASSERT(a_cnt_grows, (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1),
              "queue count did not grow on a lone push")

endmodule

`default_nettype wire

// File: rtl/core/ptx_back.sv
// ----------------------------------------------------------------------------
// Transmitter back
// Command sequencer: crossing waits, burst timing and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ptx_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ptx_pkg::cfg_t     cfg_i,
  input  wire ptx_pkg::q_head_t  head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output ptx_pkg::out_item_t     out_data_o
);

  ptx_pkg::section_e sec_q, sec_d;
  logic [2:0]  bit_idx_q, bit_idx_d;
  logic        comp_q, comp_d;
  logic [1:0]  burst_cnt_q, burst_cnt_d;
  logic        high_q, high_d;
  logic [15:0] tick_q, tick_d;
  logic        waiting_q, waiting_d;
  logic        ref_q, ref_d;
  logic [2:0]  cross_left_q, cross_left_d;
  logic [3:0]  house_q, house_d;
  logic [4:0]  number_q, number_d;
  logic        line_q, line_d;

  logic        out_valid_q, out_valid_d;
  ptx_pkg::out_item_t out_data_q, out_data_d;

  logic        pop;
  logic        zc;
  logic        bit_now;
  logic [15:0] pulse_len;
  logic        do_adv;
  logic        a_high;
  logic [1:0]  a_burst;
  logic [15:0] a_tick;
  logic [15:0] tick_inc;
  logic [2:0]  bit_inc;
  logic        tx, busy, done;

  assign pop   = head_i.valid && (!out_valid_q || !out_stall_i);
  assign pop_o = pop;
  assign zc    = head_i.entry.zero_cross;

  assign bit_now   = ptx_pkg::cur_bit(sec_q, bit_idx_q, comp_q, cfg_i.start_code,
                                      house_q, number_q);
  assign pulse_len = (cfg_i.pulse_ticks == '0) ? 16'd1 : cfg_i.pulse_ticks;

  always_comb begin
    sec_d        = sec_q;
    bit_idx_d    = bit_idx_q;
    comp_d       = comp_q;
    burst_cnt_d  = burst_cnt_q;
    high_d       = high_q;
    tick_d       = tick_q;
    waiting_d    = waiting_q;
    ref_d        = ref_q;
    cross_left_d = cross_left_q;
    house_d      = house_q;
    number_d     = number_q;
    line_d       = line_q;
    tx           = 1'b0;
    busy         = 1'b0;
    done         = 1'b0;
    do_adv       = 1'b0;
    a_high       = high_q;
    a_burst      = burst_cnt_q;
    a_tick       = tick_q;
    tick_inc     = '0;
    bit_inc      = '0;

    if (pop) begin
      if (sec_q == ptx_pkg::SEC_IDLE) begin
        bit_idx_d    = '0;
        comp_d       = 1'b0;
        burst_cnt_d  = '0;
        high_d       = 1'b0;
        tick_d       = '0;
        waiting_d    = 1'b0;
        cross_left_d = '0;
        line_d       = 1'b0;
        if (head_i.entry.is_request) begin
          house_d      = head_i.entry.house_code;
          number_d     = head_i.entry.number_code;
          sec_d        = ptx_pkg::SEC_START;
          waiting_d    = 1'b1;
          cross_left_d = 3'd1;
          ref_d        = zc;
          busy         = 1'b1;
        end
      end else begin
        busy = 1'b1;
        if (waiting_q) begin
          if (zc != ref_q) begin
            ref_d        = zc;
            cross_left_d = cross_left_q - 1'b1;
            if (cross_left_d == '0) begin
              waiting_d = 1'b0;
              if (sec_q == ptx_pkg::SEC_TAIL) begin
                sec_d       = ptx_pkg::SEC_IDLE;
                bit_idx_d   = '0;
                comp_d      = 1'b0;
                burst_cnt_d = '0;
                high_d      = 1'b0;
                tick_d      = '0;
                line_d      = 1'b0;
                done        = 1'b1;
              end else begin
                // The first high half starts on the crossing itself.
                line_d  = bit_now;
                tx      = bit_now;
                do_adv  = 1'b1;
                a_high  = 1'b1;
                a_burst = '0;
                a_tick  = '0;
              end
            end
          end
        end else begin
          tx     = line_q;
          do_adv = 1'b1;
        end
      end

      if (do_adv) begin
        tick_inc    = a_tick + 1'b1;
        high_d      = a_high;
        burst_cnt_d = a_burst;
        tick_d      = tick_inc;
        if (tick_inc >= pulse_len) begin
          tick_d = '0;
          if (a_high) begin
            high_d = 1'b0;
            line_d = 1'b0;
          end else begin
            burst_cnt_d = a_burst + 1'b1;
            if (burst_cnt_d >= ptx_pkg::BURSTS_PER_BIT) begin
              // Bit finished: move to its complement or to the next bit.
              line_d = 1'b0;
              if (sec_q != ptx_pkg::SEC_START && !comp_q) begin
                comp_d       = 1'b1;
                waiting_d    = 1'b1;
                cross_left_d = 3'd1;
                ref_d        = zc;
              end else begin
                comp_d  = 1'b0;
                bit_inc = bit_idx_q + 1'b1;
                if (bit_inc >= ptx_pkg::sec_len(sec_q)) begin
                  bit_idx_d = '0;
                  sec_d     = ptx_pkg::sec_next(sec_q);
                  if (sec_d == ptx_pkg::SEC_TAIL) begin
                    if (number_q != cfg_i.bright_code && number_q != cfg_i.dim_code) begin
                      waiting_d    = 1'b1;
                      cross_left_d = ptx_pkg::TAIL_CROSSINGS;
                      ref_d        = zc;
                    end else begin
                      sec_d        = ptx_pkg::SEC_IDLE;
                      burst_cnt_d  = '0;
                      high_d       = 1'b0;
                      waiting_d    = 1'b0;
                      cross_left_d = '0;
                      done         = 1'b1;
                    end
                  end else begin
                    waiting_d    = 1'b1;
                    cross_left_d = 3'd1;
                    ref_d        = zc;
                  end
                end else begin
                  bit_idx_d    = bit_inc;
                  waiting_d    = 1'b1;
                  cross_left_d = 3'd1;
                  ref_d        = zc;
                end
              end
            end else begin
              high_d = 1'b1;
              line_d = bit_now;
            end
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (pop) begin
      out_valid_d         = 1'b1;
      out_data_d.tx_level = tx;
      out_data_d.busy_res = busy;
      out_data_d.done_res = done;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q        <= ptx_pkg::SEC_IDLE;
      bit_idx_q    <= '0;
      comp_q       <= 1'b0;
      burst_cnt_q  <= '0;
      high_q       <= 1'b0;
      tick_q       <= '0;
      waiting_q    <= 1'b0;
      ref_q        <= 1'b0;
      cross_left_q <= '0;
      house_q      <= '0;
      number_q     <= '0;
      line_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      sec_q        <= sec_d;
      bit_idx_q    <= bit_idx_d;
      comp_q       <= comp_d;
      burst_cnt_q  <= burst_cnt_d;
      high_q       <= high_d;
      tick_q       <= tick_d;
      waiting_q    <= waiting_d;
      ref_q        <= ref_d;
      cross_left_q <= cross_left_d;
      house_q      <= house_d;
      number_q     <= number_d;
      line_q       <= line_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `PTX_ASSERT_NEVER(a_done_without_busy,
                    out_valid_q && out_data_q.done_res && !out_data_q.busy_res,
                    "done result without busy")
  `PTX_ASSERT_NEVER(a_line_high_while_waiting, waiting_q && line_q,
                    "line driven high during a crossing wait")

endmodule

`default_nettype wire

// File: rtl/core/powerline_command_transmitter_core.sv
// ----------------------------------------------------------------------------
// Powerline command transmitter core
// Top level: configuration registers, item front and command sequencer.
// ----------------------------------------------------------------------------
// Feed one input item per clock tick on the in channel (in_valid_i / in_stall_o);
// each carries the sampled zero-cross level and, while the block is idle, may
// carry a command request with its house and number codes. Every item gives
// exactly one result item on the out channel (out_valid_o / out_stall_i) with
// the line level for that tick, busy and done.
// Throughput is one item per cycle unless the receiver stalls; the sequencer
// updates its whole state for an item as it pops it. An accepted item passes
// through the queue and then the result register. When the receiver stalls,
// the result register holds, the queue fills, and in_stall_o rises once the
// queue holds QueueDepth items. Reset puts the sequencer in idle with the line
// low and loads the register defaults: pulse ticks 1000, start code 14, bright
// code 11, dim code 9. The user must write registers through cfg_we_i /
// cfg_index_i / cfg_data_i only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module powerline_command_transmitter_core #(
  parameter int unsigned QueueDepth = ptx_pkg::QUEUE_DEPTH
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [ptx_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  wire logic [ptx_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire ptx_pkg::in_item_t                 in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output ptx_pkg::out_item_t                     out_data_o
);

  ptx_pkg::cfg_t    cfg_q, cfg_d;
  ptx_pkg::q_head_t head;
  logic             pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        ptx_pkg::CFG_PULSE_TICKS: cfg_d.pulse_ticks = cfg_data_i;
        ptx_pkg::CFG_START_CODE:  cfg_d.start_code  = cfg_data_i[3:0];
        ptx_pkg::CFG_BRIGHT_CODE: cfg_d.bright_code = cfg_data_i[4:0];
        ptx_pkg::CFG_DIM_CODE:    cfg_d.dim_code    = cfg_data_i[4:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ptx_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ptx_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  ptx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
